/* rtl/apps_pkg.sv */
`timescale 1ns / 1ps

package apps_pkg;

    localparam int EXP_TERMS = 16;
    localparam int TERM_IW   = $clog2(EXP_TERMS);
    localparam int MUL_W     = 33;
    localparam int CFG_IW    = 3;

    localparam logic [CFG_IW-1:0] CFG_SPOT_START     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_STRIKE_LEVEL   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_KNOCKOUT_LEVEL = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DAILY_AMOUNT   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_ACCEL_FACTOR   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_START_QUANTITY = 3'd5;

    localparam logic [23:0]        LN2_Q24    = 24'd11629080;
    localparam logic [8:0]         LN2_RECIP  = 9'd369;
    localparam logic signed [35:0] X_LIMIT    = 36'sd395388720;
    localparam logic [30:0]        ONE_Q30    = 31'h40000000;
    localparam logic [47:0]        MAX_QTY    = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0]        MAX_PRICE  = 32'hFFFF_FFFF;
    localparam logic [23:0]        ACCEL_ONE  = 24'd65536;
    localparam logic [63:0]        PAY_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]        PAY_MIN    = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [31:0] spot_start;
        logic [31:0] strike_level;
        logic [31:0] knockout_level;
        logic [47:0] daily_amount;
        logic [23:0] accel_factor;
        logic [47:0] start_quantity;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] log_drift;
        logic [30:0]        log_diffusion;
        logic [30:0]        day_discount;
        logic signed [31:0] normal_sample;
        logic               path_first;
        logic               path_last;
    } item_t;

    typedef struct packed {
        logic signed [63:0] path_payoff;
        logic               knocked_out;
        logic               saturated;
    } res_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_stat_t;

    // floor(2^32 / idx), idx from 1 up
    function automatic logic [MUL_W-1:0] term_recip(input logic [4:0] idx);
        logic [MUL_W-1:0] r;
        case (idx)
            5'd1:    r = 33'd4294967296;
            5'd2:    r = 33'd2147483648;
            5'd3:    r = 33'd1431655765;
            5'd4:    r = 33'd1073741824;
            5'd5:    r = 33'd858993459;
            5'd6:    r = 33'd715827882;
            5'd7:    r = 33'd613566756;
            5'd8:    r = 33'd536870912;
            5'd9:    r = 33'd477218588;
            5'd10:   r = 33'd429496729;
            5'd11:   r = 33'd390451572;
            5'd12:   r = 33'd357913941;
            5'd13:   r = 33'd330382099;
            5'd14:   r = 33'd306783378;
            5'd15:   r = 33'd286331153;
            5'd16:   r = 33'd268435456;
            5'd17:   r = 33'd252645135;
            5'd18:   r = 33'd238609294;
            5'd19:   r = 33'd226050910;
            5'd20:   r = 33'd214748364;
            5'd21:   r = 33'd204522252;
            5'd22:   r = 33'd195225786;
            5'd23:   r = 33'd186737708;
            5'd24:   r = 33'd178956970;
            5'd25:   r = 33'd171798691;
            5'd26:   r = 33'd165191049;
            5'd27:   r = 33'd159072862;
            5'd28:   r = 33'd153391689;
            5'd29:   r = 33'd148102320;
            5'd30:   r = 33'd143165576;
            5'd31:   r = 33'd138547332;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/apps_mul.sv */
`timescale 1ns / 1ps

module apps_mul
(
    input  logic                          clk,
    input  logic [apps_pkg::MUL_W-1:0]    op_a,
    input  logic [apps_pkg::MUL_W-1:0]    op_b,
    output logic [2*apps_pkg::MUL_W-1:0]  prod
);

    logic [2*apps_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= (2*apps_pkg::MUL_W)'(op_a) * (2*apps_pkg::MUL_W)'(op_b);
    end

    assign prod = prod_reg;

endmodule

/* rtl/apps_engine.sv */
`timescale 1ns / 1ps

module apps_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  apps_pkg::item_t    item,
    input  apps_pkg::cfg_t     cfg,
    input  logic               res_ready,
    output apps_pkg::eng_stat_t stat,
    output apps_pkg::res_t     res
);

    typedef enum logic [4:0] {
        S_IDLE, S_XMUL, S_XSUM, S_KDIV, S_KREM, S_TMUL, S_TDIV, S_TCOR,
        S_GMUL, S_GSHF, S_AMUL1, S_AMUL2, S_AADD, S_ACC, S_FIN,
        S_PD, S_PP1, S_PP2, S_PP3, S_PP4, S_PP5, S_PRND, S_DONE
    } state_t;

    state_t                        state_reg;
    apps_pkg::item_t               item_reg;
    logic [31:0]                   value_reg;
    logic [31:0]                   term_v_reg;
    logic [47:0]                   hq_reg;
    logic [30:0]                   disc_reg;
    logic                          knock_reg;
    logic                          sat_reg;
    logic signed [35:0]            x_reg;
    logic [28:0]                   a_reg;
    logic [5:0]                    q_reg;
    logic signed [6:0]             k_reg;
    logic [31:0]                   r32_reg;
    logic [32:0]                   term_reg;
    logic [34:0]                   sum_reg;
    logic [apps_pkg::TERM_IW-1:0]  i_reg;
    logic [31:0]                   t_reg;
    logic [55:0]                   p1_reg;
    logic [56:0]                   add_reg;
    logic [62:0]                   d_reg;
    logic                          neg_reg;
    logic [111:0]                  acc_reg;
    apps_pkg::res_t                res_reg;

    logic [apps_pkg::MUL_W-1:0]    op_a;
    logic [apps_pkg::MUL_W-1:0]    op_b;
    logic [2*apps_pkg::MUL_W-1:0]  prod;

    logic [31:0]                   nmag;
    logic signed [63:0]            pval;
    logic signed [63:0]            prnd;
    logic signed [35:0]            xcalc;
    logic [35:0]                   xabs;
    logic                          x_hi;
    logic                          x_lo;
    logic [5:0]                    qk;
    logic [29:0]                   rem0;
    logic [29:0]                   rem1;
    logic [5:0]                    q1;
    logic signed [6:0]             k_calc;
    logic [23:0]                   r_calc;
    logic [32:0]                   tq0;
    logic [37:0]                   trem;
    logic [32:0]                   tq;
    logic [31:0]                   exp_r;
    logic signed [7:0]             shamt;
    logic [63:0]                   gprod;
    logic [64:0]                   gres;
    logic [31:0]                   grown;
    logic                          gsat;
    logic [31:0]                   diff;
    logic [63:0]                   rlo;
    logic [64:0]                   rsum;
    logic                          povf;
    logic [63:0]                   pay;

    apps_mul u_mul
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_XMUL:
            begin
                op_a = {2'b0, item_reg.log_diffusion};
                op_b = {1'b0, nmag};
            end
            S_TMUL:
            begin
                op_a = term_reg;
                op_b = {1'b0, r32_reg};
            end
            S_TDIV:
            begin
                op_a = {1'b0, prod[63:32]};
                op_b = apps_pkg::term_recip(5'(i_reg));
            end
            S_GMUL:
            begin
                op_a = {1'b0, value_reg};
                op_b = {1'b0, exp_r};
            end
            S_AMUL1:
            begin
                op_a = {1'b0, cfg.daily_amount[47:16]};
                op_b = {9'b0, cfg.accel_factor};
            end
            S_AMUL2:
            begin
                op_a = {17'b0, cfg.daily_amount[15:0]};
                op_b = {9'b0, cfg.accel_factor};
            end
            S_PD:
            begin
                op_a = {1'b0, diff};
                op_b = {2'b0, disc_reg};
            end
            S_PP1:
            begin
                op_a = {9'b0, hq_reg[23:0]};
                op_b = {1'b0, prod[31:0]};
            end
            S_PP2:
            begin
                op_a = {9'b0, hq_reg[23:0]};
                op_b = {2'b0, d_reg[62:32]};
            end
            S_PP3:
            begin
                op_a = {9'b0, hq_reg[47:24]};
                op_b = {1'b0, d_reg[31:0]};
            end
            S_PP4:
            begin
                op_a = {9'b0, hq_reg[47:24]};
                op_b = {2'b0, d_reg[62:32]};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // exponent and range reduction
    always_comb
    begin
        nmag  = item_reg.normal_sample[31] ? 32'(-item_reg.normal_sample)
                                           : 32'(item_reg.normal_sample);
        pval  = item_reg.normal_sample[31] ? -$signed({1'b0, prod[62:0]})
                                           : $signed({1'b0, prod[62:0]});
        prnd  = pval + 64'sd134217728;
        xcalc = 36'(prnd >>> 28) + 36'(item_reg.log_drift);
        xabs  = x_reg[35] ? 36'(-x_reg) : 36'(x_reg);
        x_hi  = x_reg >= apps_pkg::X_LIMIT;
        x_lo  = x_reg < -apps_pkg::X_LIMIT;
        qk    = 6'((38'(xabs[28:0]) * 38'(apps_pkg::LN2_RECIP)) >> 32);
        rem0  = 30'(a_reg) - 30'(30'(q_reg) * 30'(apps_pkg::LN2_Q24));
        if (rem0 >= 30'(apps_pkg::LN2_Q24))
        begin
            q1   = q_reg + 6'd1;
            rem1 = rem0 - 30'(apps_pkg::LN2_Q24);
        end
        else
        begin
            q1   = q_reg;
            rem1 = rem0;
        end
        if (x_reg[35] && rem1 != '0)
        begin
            k_calc = -(7'(q1) + 7'sd1);
            r_calc = apps_pkg::LN2_Q24 - 24'(rem1);
        end
        else if (x_reg[35])
        begin
            k_calc = -7'(q1);
            r_calc = '0;
        end
        else
        begin
            k_calc = 7'(q1);
            r_calc = 24'(rem1);
        end
    end

    // series term divide correction
    always_comb
    begin
        tq0   = prod[64:32];
        trem  = 38'(t_reg) - 38'(38'(tq0) * 38'(i_reg));
        tq    = (trem >= 38'(i_reg)) ? tq0 + 33'd1 : tq0;
        exp_r = 32'((36'(sum_reg) + 36'd2) >> 2);
    end

    // scale by 2^k with rounding and clamp
    always_comb
    begin
        gprod = prod[63:0];
        shamt = 8'sd30 - 8'(k_reg);
        gres  = '0;
        gsat  = 1'b0;
        if (gprod == '0 || x_lo)
        begin
            gres = '0;
        end
        else if (x_hi)
        begin
            gsat = 1'b1;
        end
        else if (shamt >= 8'sd64)
        begin
            gres = '0;
        end
        else if (shamt > 8'sd0)
        begin
            gres = 65'(gprod >> 7'(shamt)) + 65'((gprod >> (7'(shamt) - 7'd1)) & 64'd1);
        end
        else if (shamt == 8'sd0)
        begin
            gres = 65'(gprod);
        end
        else if (gprod > 64'(apps_pkg::MAX_PRICE >> 2'(-shamt)))
        begin
            gsat = 1'b1;
        end
        else
        begin
            gres = 65'(gprod << 2'(-shamt));
        end
        if (gres > 65'(apps_pkg::MAX_PRICE))
        begin
            gsat = 1'b1;
        end
        grown = gsat ? apps_pkg::MAX_PRICE : 32'(gres);
    end

    // payoff rounding and clamp
    always_comb
    begin
        diff = (term_v_reg < cfg.strike_level) ? cfg.strike_level - term_v_reg
                                               : term_v_reg - cfg.strike_level;
        rlo  = acc_reg[109:46];
        rsum = 65'(rlo) + 65'(acc_reg[45]);
        povf = (acc_reg[111:110] != '0) || rsum[64] ||
               (rsum[63:0] > (neg_reg ? apps_pkg::PAY_MIN : apps_pkg::PAY_MAX));
        if (povf)
            pay = neg_reg ? apps_pkg::PAY_MIN : apps_pkg::PAY_MAX;
        else
            pay = neg_reg ? -rsum[63:0] : rsum[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            item_reg   <= '0;
            value_reg  <= '0;
            term_v_reg <= '0;
            hq_reg     <= '0;
            disc_reg   <= apps_pkg::ONE_Q30;
            knock_reg  <= 1'b0;
            sat_reg    <= 1'b0;
            x_reg      <= '0;
            a_reg      <= '0;
            q_reg      <= '0;
            k_reg      <= '0;
            r32_reg    <= '0;
            term_reg   <= '0;
            sum_reg    <= '0;
            i_reg      <= '0;
            t_reg      <= '0;
            p1_reg     <= '0;
            add_reg    <= '0;
            d_reg      <= '0;
            neg_reg    <= 1'b0;
            acc_reg    <= '0;
            res_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg <= item;
                        if (item.path_first)
                        begin
                            value_reg  <= cfg.spot_start;
                            term_v_reg <= cfg.spot_start;
                            hq_reg     <= cfg.start_quantity;
                            disc_reg   <= apps_pkg::ONE_Q30;
                            knock_reg  <= 1'b0;
                            sat_reg    <= 1'b0;
                        end
                        state_reg <= (item.path_first || !knock_reg) ? S_XMUL : S_FIN;
                    end
                end
                S_XMUL:
                    state_reg <= S_XSUM;
                S_XSUM:
                begin
                    x_reg     <= xcalc;
                    state_reg <= S_KDIV;
                end
                S_KDIV:
                begin
                    a_reg     <= xabs[28:0];
                    q_reg     <= qk;
                    state_reg <= S_KREM;
                end
                S_KREM:
                begin
                    k_reg     <= k_calc;
                    r32_reg   <= {r_calc, 8'b0};
                    term_reg  <= 33'h1_0000_0000;
                    sum_reg   <= 35'h1_0000_0000;
                    i_reg     <= apps_pkg::TERM_IW'(1);
                    state_reg <= S_TMUL;
                end
                S_TMUL:
                    state_reg <= S_TDIV;
                S_TDIV:
                begin
                    t_reg     <= prod[63:32];
                    state_reg <= S_TCOR;
                end
                S_TCOR:
                begin
                    term_reg <= tq;
                    sum_reg  <= sum_reg + 35'(tq);
                    if (i_reg == apps_pkg::TERM_IW'(apps_pkg::EXP_TERMS - 1))
                    begin
                        state_reg <= S_GMUL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + apps_pkg::TERM_IW'(1);
                        state_reg <= S_TMUL;
                    end
                end
                S_GMUL:
                    state_reg <= S_GSHF;
                S_GSHF:
                begin
                    value_reg  <= grown;
                    term_v_reg <= grown;
                    disc_reg   <= item_reg.day_discount;
                    if (gsat)
                        sat_reg <= 1'b1;
                    if (grown >= cfg.knockout_level)
                    begin
                        knock_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else if (grown < cfg.strike_level)
                    begin
                        state_reg <= S_AMUL1;
                    end
                    else
                    begin
                        add_reg   <= 57'(cfg.daily_amount);
                        state_reg <= S_ACC;
                    end
                end
                S_AMUL1:
                    state_reg <= S_AMUL2;
                S_AMUL2:
                begin
                    p1_reg    <= prod[55:0];
                    state_reg <= S_AADD;
                end
                S_AADD:
                begin
                    add_reg   <= 57'(p1_reg) + 57'(prod[39:16]);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (add_reg > 57'(apps_pkg::MAX_QTY - hq_reg))
                    begin
                        hq_reg  <= apps_pkg::MAX_QTY;
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        hq_reg <= hq_reg + 48'(add_reg);
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                    state_reg <= item_reg.path_last ? S_PD : S_IDLE;
                S_PD:
                begin
                    neg_reg   <= term_v_reg < cfg.strike_level;
                    state_reg <= S_PP1;
                end
                S_PP1:
                begin
                    d_reg     <= prod[62:0];
                    state_reg <= S_PP2;
                end
                S_PP2:
                begin
                    acc_reg   <= 112'(prod);
                    state_reg <= S_PP3;
                end
                S_PP3:
                begin
                    acc_reg   <= acc_reg + (112'(prod) << 32);
                    state_reg <= S_PP4;
                end
                S_PP4:
                begin
                    acc_reg   <= acc_reg + (112'(prod) << 24);
                    state_reg <= S_PP5;
                end
                S_PP5:
                begin
                    acc_reg   <= acc_reg + (112'(prod) << 56);
                    state_reg <= S_PRND;
                end
                S_PRND:
                begin
                    if (povf)
                        sat_reg <= 1'b1;
                    res_reg.path_payoff <= $signed(pay);
                    res_reg.knocked_out <= knock_reg;
                    res_reg.saturated   <= sat_reg | povf;
                    state_reg           <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign stat.idle      = (state_reg == S_IDLE);
    assign stat.res_valid = (state_reg == S_DONE);
    assign res            = res_reg;

endmodule

/* rtl/accumulator_path_payoff_step_core.sv */
`timescale 1ns / 1ps
// one trading day per input transfer, one shared 33x33 multiplier under a sequencer
// a day runs the exp series loop and a quantity update (accelerated below strike), the payoff on the last day
// a day after knock-out skips straight to the finish state (payoff on the last day); the exp series loop dominates
// one item at a time: s_axis_tready low while a day is in progress
// rst_n (async, active low) restores register defaults and clears path state and output

module accumulator_path_payoff_step_core
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // log_drift, log_diffusion, day_discount, normal_sample, 2 bits zero pad
    input  logic [127:0]                  s_axis_tdata,
    // path_first
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tlast,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // path_payoff
    output logic [63:0]                   m_axis_tdata,
    // knocked_out, saturated
    output logic [1:0]                    m_axis_tuser,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [apps_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [47:0]                   cfg_data
);

    apps_pkg::cfg_t      cfg_reg;
    apps_pkg::item_t     item;
    apps_pkg::eng_stat_t stat;
    apps_pkg::res_t      res;
    apps_pkg::res_t      out_reg;
    logic                out_valid_reg;
    logic                res_ready;
    logic                start;

    assign item.log_drift     = $signed(s_axis_tdata[31:0]);
    assign item.log_diffusion = s_axis_tdata[62:32];
    assign item.day_discount  = s_axis_tdata[93:63];
    assign item.normal_sample = $signed(s_axis_tdata[125:94]);
    assign item.path_first    = s_axis_tuser;
    assign item.path_last     = s_axis_tlast;

    assign s_axis_tready = stat.idle;
    assign start         = s_axis_tvalid & stat.idle;
    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    apps_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg       (cfg_reg),
        .res_ready (res_ready),
        .stat      (stat),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spot_start     <= '0;
            cfg_reg.strike_level   <= '0;
            cfg_reg.knockout_level <= apps_pkg::MAX_PRICE;
            cfg_reg.daily_amount   <= '0;
            cfg_reg.accel_factor   <= apps_pkg::ACCEL_ONE;
            cfg_reg.start_quantity <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                apps_pkg::CFG_SPOT_START:     cfg_reg.spot_start     <= cfg_data[31:0];
                apps_pkg::CFG_STRIKE_LEVEL:   cfg_reg.strike_level   <= cfg_data[31:0];
                apps_pkg::CFG_KNOCKOUT_LEVEL: cfg_reg.knockout_level <= cfg_data[31:0];
                apps_pkg::CFG_DAILY_AMOUNT:   cfg_reg.daily_amount   <= cfg_data;
                apps_pkg::CFG_ACCEL_FACTOR:   cfg_reg.accel_factor   <= cfg_data[23:0];
                apps_pkg::CFG_START_QUANTITY: cfg_reg.start_quantity <= cfg_data;
                default:                      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // output register, refilled straight from the engine when drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (stat.res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
            out_reg       <= res;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.path_payoff;
    assign m_axis_tuser  = {out_reg.saturated, out_reg.knocked_out};

endmodule

/* rtl/apps_checker.sv */
`timescale 1ns / 1ps

module apps_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a day occupies the engine, so no back-to-back input transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a day is in progress");

    // a result never shows up right after the input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared one cycle after input transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

endmodule

bind accumulator_path_payoff_step_core apps_checker u_apps_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/accumulator_path_payoff_step_core_tb.sv */
`timescale 1ns / 1ps

module accumulator_path_payoff_step_core_tb;

    import apps_pkg::*;

    localparam int  DRAIN_CYCLES = 120;
    localparam int  STALL_LIMIT  = 20000;
    localparam longint LN2       = 64'd11629080;
    localparam longint unsigned M32 = 64'hFFFF_FFFF;
    localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [127:0]        s_axis_tdata;
    logic                s_axis_tuser;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [63:0]         m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_IW-1:0]   cfg_index;
    logic [47:0]         cfg_data;

    accumulator_path_payoff_step_core dut (.*);

    // path state mirrored from the block
    cfg_t                 regs;
    logic [31:0]          asset, terminal;
    logic [47:0]          quantity;
    logic [30:0]          discount;
    bit                   knocked, sat;

    item_t                day_queue[$];
    res_t                 payoff_queue[$];
    item_t                cur_day;
    bit                   s_fire;
    int                   send_idle_pct, recv_idle_pct;
    int                   errors;
    int                   stall_count;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] grow_price(input logic [31:0] v, input longint x);
        longint            k, s, n;
        longint unsigned   r32, term, sum, prod, res;
        k = x / LN2;
        if ((x % LN2) != 0 && x < 0)
            k--;
        r32 = longint'(x - k * LN2) << 8;
        term = 64'd1 << 32;
        sum = term;
        for (int i = 1; i < EXP_TERMS; i++)
        begin
            term = ((term * r32) >> 32) / longint'(i);
            sum += term;
        end
        prod = longint'(v) * ((sum + 2) >> 2);
        if (prod == 0)
            return 32'd0;
        s = 30 - k;
        if (s >= 64)
            res = 0;
        else if (s > 0)
            res = (prod >> s) + ((prod >> (s - 1)) & 1);
        else if (s == 0)
            res = prod;
        else
        begin
            n = -s;
            if (n >= 32 || prod > (M32 >> n))
            begin
                sat = 1'b1;
                return MAX_PRICE;
            end
            res = prod << n;
        end
        if (res > M32)
        begin
            sat = 1'b1;
            return MAX_PRICE;
        end
        return res[31:0];
    endfunction

    function automatic logic [63:0] settle_payoff();
        bit                neg;
        logic [127:0]      p, r;
        logic [63:0]       lim;
        neg = terminal < regs.strike_level;
        p = 128'(quantity) * 128'(64'(neg ? regs.strike_level - terminal
                                          : terminal - regs.strike_level) * 64'(discount));
        r = (p >> 46) + 128'(p[45]);
        lim = neg ? PAY_MIN : PAY_MAX;
        if (r[127:64] != 0 || r[63:0] > lim)
        begin
            sat = 1'b1;
            return lim;
        end
        return neg ? (~r[63:0] + 64'd1) : r[63:0];
    endfunction

    // advance one day, push the payoff when the path ends
    task automatic step_day(input item_t d);
        longint            x;
        longint unsigned   add;
        res_t              r;
        if (d.path_first)
        begin
            asset = regs.spot_start;
            terminal = regs.spot_start;
            quantity = regs.start_quantity;
            discount = ONE_Q30;
            knocked = 1'b0;
            sat = 1'b0;
        end
        if (!knocked)
        begin
            x = ((longint'(d.log_diffusion) * longint'(d.normal_sample) + (64'sd1 <<< 27))
                 >>> 28) + longint'(d.log_drift);
            asset = grow_price(asset, x);
            discount = d.day_discount;
            terminal = asset;
            if (asset >= regs.knockout_level)
                knocked = 1'b1;
            else
            begin
                add = regs.daily_amount;
                if (asset < regs.strike_level)
                    add = (longint'(regs.daily_amount) >> 16) * regs.accel_factor
                        + (((longint'(regs.daily_amount) & 64'hFFFF) * regs.accel_factor) >> 16);
                if (add > M48 - quantity)
                begin
                    quantity = MAX_QTY;
                    sat = 1'b1;
                end
                else
                    quantity = quantity + add[47:0];
            end
        end
        if (d.path_last)
        begin
            r.path_payoff = settle_payoff();
            r.knocked_out = knocked;
            r.saturated = sat;
            payoff_queue.push_back(r);
        end
    endtask

    // input driver and output ready
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_fire)
        begin
            if (day_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_day = day_queue.pop_front();
                s_axis_tdata <= {2'b00, cur_day.normal_sample, cur_day.day_discount,
                                 cur_day.log_diffusion, cur_day.log_drift};
                s_axis_tuser <= cur_day.path_first;
                s_axis_tlast <= cur_day.path_last;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        res_t want;
        s_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                step_day(cur_day);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (payoff_queue.size() == 0)
                    report("unexpected transfer", m_axis_tdata, 64'd0);
                else
                begin
                    want = payoff_queue.pop_front();
                    if (m_axis_tdata !== want.path_payoff)
                        report("path_payoff", m_axis_tdata, want.path_payoff);
                    if (m_axis_tuser[0] !== want.knocked_out)
                        report("knocked_out", m_axis_tuser[0], want.knocked_out);
                    if (m_axis_tuser[1] !== want.saturated)
                        report("saturated", m_axis_tuser[1], want.saturated);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [47:0] val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SPOT_START:     regs.spot_start = val[31:0];
            CFG_STRIKE_LEVEL:   regs.strike_level = val[31:0];
            CFG_KNOCKOUT_LEVEL: regs.knockout_level = val[31:0];
            CFG_DAILY_AMOUNT:   regs.daily_amount = val;
            CFG_ACCEL_FACTOR:   regs.accel_factor = val[23:0];
            default:            regs.start_quantity = val;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input cfg_t c);
        write_reg(CFG_SPOT_START, 48'(c.spot_start));
        write_reg(CFG_STRIKE_LEVEL, 48'(c.strike_level));
        write_reg(CFG_KNOCKOUT_LEVEL, 48'(c.knockout_level));
        write_reg(CFG_DAILY_AMOUNT, c.daily_amount);
        write_reg(CFG_ACCEL_FACTOR, 48'(c.accel_factor));
        write_reg(CFG_START_QUANTITY, c.start_quantity);
    endtask

    function automatic cfg_t market_cfg();
        cfg_t c;
        c.spot_start = $urandom_range(20, 200) << 16;
        c.strike_level = c.spot_start + ($urandom_range(0, 40) << 16) - (20 << 16);
        c.knockout_level = ($urandom_range(9) == 0) ? MAX_PRICE
                         : c.spot_start + ($urandom_range(2, 40) << 16);
        c.daily_amount = {$urandom, $urandom} >> $urandom_range(16, 40);
        c.accel_factor = $urandom_range(0, 4 << 16);
        c.start_quantity = {$urandom, $urandom} >> $urandom_range(16, 48);
        if ($urandom_range(3) == 0) c.spot_start = $urandom_range(1) ? MAX_PRICE : 32'd0;
        if ($urandom_range(3) == 0) c.strike_level = $urandom_range(1) ? MAX_PRICE : 32'd0;
        if ($urandom_range(5) == 0) c.knockout_level = $urandom;
        if ($urandom_range(5) == 0) c.daily_amount = $urandom_range(1) ? MAX_QTY : 48'd0;
        if ($urandom_range(5) == 0) c.accel_factor = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
        if ($urandom_range(5) == 0) c.start_quantity = {$urandom, $urandom};
        return c;
    endfunction

    task automatic add_day(input logic [31:0] drift, input logic [30:0] diff,
                           input logic [30:0] disc, input logic [31:0] z,
                           input bit first, input bit last);
        item_t d;
        d.log_drift = drift;
        d.log_diffusion = diff;
        d.day_discount = disc;
        d.normal_sample = z;
        d.path_first = first;
        d.path_last = last;
        day_queue.push_back(d);
    endtask

    task automatic add_path();
        int  len;
        bit  broken;
        len = $urandom_range(1, 12);
        broken = ($urandom_range(19) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(11) == 0)
                add_day($urandom, $urandom, $urandom_range(0, ONE_Q30), $urandom,
                        $urandom_range(1), $urandom_range(1));
            else
                add_day(32'($urandom_range(0, 1 << 21)) - 32'(1 << 20),
                        $urandom_range(0, 1 << 22), $urandom_range(1 << 29, ONE_Q30),
                        32'($urandom_range(0, 32'h6000_0000)) - 32'h3000_0000,
                        (i == 0) ^ (broken && $urandom_range(1)),
                        (i == len - 1) ^ (broken && $urandom_range(1)));
        end
    endtask

    task automatic settle();
        while (day_queue.size() != 0 || s_axis_tvalid || payoff_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        cfg_t  c;
        int    sent;
        errors = 0;
        stall_count = 0;
        s_fire = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SPOT_START;
        cfg_data = '0;
        regs.spot_start = '0;
        regs.strike_level = '0;
        regs.knockout_level = MAX_PRICE;
        regs.daily_amount = '0;
        regs.accel_factor = ACCEL_ONE;
        regs.start_quantity = '0;
        asset = '0;
        terminal = '0;
        quantity = '0;
        discount = ONE_Q30;
        knocked = 1'b0;
        sat = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 75;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults, path without a start
        add_day(32'd0, 31'd0, ONE_Q30, 32'd0, 1'b0, 1'b1);
        settle();
        c.spot_start = 100 << 16;
        c.strike_level = 100 << 16;
        c.knockout_level = 120 << 16;
        c.daily_amount = 48'h1_0000;
        c.accel_factor = 24'h2_0000;
        c.start_quantity = 48'd0;
        write_all(c);
        add_day(32'd0, 31'd0, ONE_Q30, 32'd0, 1'b1, 1'b1);
        add_day(32'h7FFF_FFFF, 31'd0, ONE_Q30, 32'd0, 1'b1, 1'b1);
        add_day(32'h8000_0000, 31'd0, ONE_Q30, 32'd0, 1'b1, 1'b1);
        add_day(32'd0, 31'h7FFF_FFFF, ONE_Q30, 32'h7FFF_FFFF, 1'b1, 1'b1);
        add_day(32'd0, 31'h7FFF_FFFF, ONE_Q30, 32'h8000_0000, 1'b1, 1'b1);
        add_day(32'hFFF0_0000, 31'h0010_0000, 31'h3000_0000, 32'h1000_0000, 1'b1, 1'b0);
        add_day(32'h0050_0000, 31'd0, 31'h3800_0000, 32'd0, 1'b0, 1'b0);
        add_day(32'hFF00_0000, 31'd0, 31'h2000_0000, 32'd0, 1'b0, 1'b1);
        add_day(32'h0001_0000, 31'd0, 31'h7FFF_FFFF, 32'd0, 1'b0, 1'b1);
        add_day(32'hFFFF_0000, 31'h7FFF_FFFF, 31'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        add_day(32'hFFC0_0000, 31'h0004_0000, ONE_Q30, 32'h3000_0000, 1'b1, 1'b0);
        add_day(32'hFFC0_0000, 31'h0004_0000, 31'h3FFF_FFFF, 32'hD000_0000, 1'b0, 1'b1);
        settle();
        c.spot_start = MAX_PRICE;
        c.strike_level = MAX_PRICE;
        c.knockout_level = MAX_PRICE;
        c.daily_amount = MAX_QTY;
        c.accel_factor = 24'hFF_FFFF;
        c.start_quantity = MAX_QTY - 48'd5;
        write_all(c);
        add_day(32'hFF00_0000, 31'd0, ONE_Q30, 32'd0, 1'b1, 1'b0);
        add_day(32'hFF00_0000, 31'd0, ONE_Q30, 32'd0, 1'b0, 1'b1);
        add_day(32'hF000_0000, 31'd0, ONE_Q30, 32'd0, 1'b1, 1'b1);
        add_day(32'd0, 31'd0, ONE_Q30, 32'd0, 1'b1, 1'b1);
        settle();
        c = '0;
        write_all(c);
        add_day(32'd0, 31'd0, ONE_Q30, 32'd0, 1'b1, 1'b1);
        add_day(32'h0100_0000, 31'd0, ONE_Q30, 32'd0, 1'b1, 1'b1);
        settle();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 11 : 0;
            sent = 0;
            while (sent < 550)
            begin
                write_all(market_cfg());
                while (day_queue.size() < 60)
                    add_path();
                sent += day_queue.size();
                settle();
            end
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
